@@ rtl/core/crc8fpr_pkg.sv @@
// shared types, constants and the crc-8 step for the framed packet receiver
// no dependencies
package crc8fpr_pkg;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CRC   = 2'd1,
        ST_LEN   = 2'd2,
        ST_TRUNC = 2'd3
    } status_t;

    localparam logic [31:0] HEAD_WORD     = 32'hAAAA_AAAA;
    localparam logic [7:0]  HEAD_BYTE     = 8'hAA;
    localparam logic [7:0]  CRC_INIT      = 8'hFF;
    localparam logic [7:0]  CRC_POLY      = 8'h31;
    localparam logic [7:0]  TYPE_BYTE     = 8'h00;
    localparam logic [7:0]  TYPE_WORD     = 8'h01;
    localparam logic [31:0] MIN_LEN_OTHER = 32'd15;
    localparam logic [31:0] MIN_LEN_BYTE  = 32'd16;
    localparam logic [31:0] MIN_LEN_WORD  = 32'd19;
    localparam int          OUT_DATA_W    = 88;

    // one byte of msb-first crc-8, same as a table lookup on crc ^ b
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // crc after the four head bytes
    localparam logic [7:0] HEAD_CRC =
        crc8_step(crc8_step(crc8_step(crc8_step(CRC_INIT, HEAD_BYTE), HEAD_BYTE),
                            HEAD_BYTE), HEAD_BYTE);

endpackage

@@ rtl/core/crc8_framed_packet_receiver_top.sv @@
// framed packet receiver: head hunt, field decode and crc-8 check per byte
// depends on crc8fpr_pkg
//
// usage:
//   s_ channel carries one received byte per beat in s_tdata[7:0]; s_tlast
//   marks the last byte of a buffer, which closes a frame still open after it
//   as truncated and restarts the head hunt with an empty history
//   m_ channel carries one beat per finished frame: m_tuser holds the status
//   (ok, crc mismatch, bad length, truncated), m_tdata the decoded id,
//   command, type and payload, all zero unless the status is ok
// result: the result of the byte that ends a frame shows on m_ in the cycle
//   after that byte is taken
// throughput: one byte per cycle while s_tready is high; the decode and the crc
//   step (one table step per byte) sit between the input handshake and the result register
// stall: the result register holds a beat until m_tready; while it is full
//   and m_tready is low, s_tready is low
// reset: hunting, empty byte history, no result pending
module crc8_framed_packet_receiver_top #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [crc8fpr_pkg::OUT_DATA_W-1:0] m_tdata,
    // frame_id[31:0], command[39:32], data_type[47:40], byte_value[55:48],
    // word_value[87:56]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import crc8fpr_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES);

    logic                  in_frame_reg, in_frame_next;
    logic [23:0]           recent_reg, recent_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [7:0]            crc_reg, crc_next;
    logic [31:0]           len_reg, len_next;
    logic [31:0]           id_reg, id_next;
    logic [7:0]            cmd_reg, cmd_next;
    logic [7:0]            type_reg, type_next;
    logic [31:0]           payload_reg, payload_next;
    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic        s_fire;
    logic [7:0]  b;
    logic [31:0] hunt_word;
    logic [31:0] len_shift;
    logic        end_hit;
    logic        emit;
    logic        go_hunt;
    logic        len_err;
    status_t     res_status;
    logic [OUT_DATA_W-1:0] res_data;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    always_comb begin
        in_frame_next = in_frame_reg;
        recent_next   = recent_reg;
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        len_next      = len_reg;
        id_next       = id_reg;
        cmd_next      = cmd_reg;
        type_next     = type_reg;
        payload_next  = payload_reg;
        emit          = 1'b0;
        go_hunt       = 1'b0;
        len_err       = 1'b0;
        res_status    = ST_OK;
        res_data      = '0;

        hunt_word = {recent_reg, b};
        len_shift = {len_reg[23:0], b};
        end_hit   = (pos_reg >= POS_W'(8)) &&
                    (({{(32-POS_W){1'b0}}, pos_reg} + 32'd1) == len_reg);

        if (s_fire) begin
            if (!in_frame_reg) begin
                recent_next = hunt_word[23:0];
                if (hunt_word == HEAD_WORD) begin
                    in_frame_next = 1'b1;
                    pos_next      = POS_W'(4);
                    crc_next      = HEAD_CRC;
                    recent_next   = '0;
                    if (s_tlast) begin
                        emit       = 1'b1;
                        res_status = ST_TRUNC;
                        go_hunt    = 1'b1;
                    end
                end else if (s_tlast) begin
                    recent_next = '0;
                end
            end else if (end_hit) begin
                emit    = 1'b1;
                go_hunt = 1'b1;
                if (crc_reg == b) begin
                    res_status     = ST_OK;
                    res_data[31:0]  = id_reg;
                    res_data[39:32] = cmd_reg;
                    res_data[47:40] = type_reg;
                    res_data[55:48] = (type_reg == TYPE_BYTE) ? payload_reg[7:0] : 8'd0;
                    res_data[87:56] = (type_reg == TYPE_WORD) ? payload_reg : 32'd0;
                end else begin
                    res_status = ST_CRC;
                end
            end else begin
                crc_next = crc8_step(crc_reg, b);
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg < POS_W'(8)) begin
                    len_next = len_shift;
                    if (pos_reg == POS_W'(7) &&
                        (len_shift > 32'(MAX_FRAME_BYTES) || len_shift < MIN_LEN_OTHER)) begin
                        len_err = 1'b1;
                    end
                end else if (pos_reg < POS_W'(12)) begin
                    id_next = {id_reg[23:0], b};
                end else if (pos_reg == POS_W'(12)) begin
                    cmd_next = b;
                end else if (pos_reg == POS_W'(13)) begin
                    type_next    = b;
                    payload_next = '0;
                    if ((b == TYPE_BYTE && len_reg < MIN_LEN_BYTE) ||
                        (b == TYPE_WORD && len_reg < MIN_LEN_WORD) ||
                        len_reg < MIN_LEN_OTHER) begin
                        len_err = 1'b1;
                    end
                end else if (pos_reg == POS_W'(14) && type_reg == TYPE_BYTE) begin
                    payload_next = {24'd0, b};
                end else if (pos_reg < POS_W'(18) && type_reg == TYPE_WORD) begin
                    payload_next = {payload_reg[23:0], b};
                end

                if (len_err) begin
                    emit       = 1'b1;
                    res_status = ST_LEN;
                    go_hunt    = 1'b1;
                end else if (s_tlast) begin
                    emit       = 1'b1;
                    res_status = ST_TRUNC;
                    go_hunt    = 1'b1;
                end
            end

            if (go_hunt) begin
                in_frame_next = 1'b0;
                recent_next   = '0;
                pos_next      = '0;
                crc_next      = CRC_INIT;
            end
        end

        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status;
            m_data_next   = res_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            recent_reg   <= '0;
            pos_reg      <= '0;
            crc_reg      <= CRC_INIT;
            m_valid_reg  <= 1'b0;
        end else begin
            in_frame_reg <= in_frame_next;
            recent_reg   <= recent_next;
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        id_reg       <= id_next;
        cmd_reg      <= cmd_next;
        type_reg     <= type_next;
        payload_reg  <= payload_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
    end

`ifndef ASSERT_OFF
    a_err_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |-> (m_data_reg == '0))
        else $error("error beat carries nonzero fields");

    a_hunt_state_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> (pos_reg == '0 && crc_reg == CRC_INIT))
        else $error("hunt state not cleared");

    a_frame_pos_past_head: assert property (@(posedge aclk) disable iff (!aresetn)
        in_frame_reg |-> (pos_reg >= POS_W'(4)))
        else $error("frame position inside head");

    a_len_checked: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_frame_reg && pos_reg >= POS_W'(8)) |->
        (len_reg <= 32'(MAX_FRAME_BYTES) && len_reg >= MIN_LEN_OTHER))
        else $error("frame open with unchecked length");

    a_last_closes_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (!in_frame_reg && recent_reg == '0))
        else $error("frame still open after last byte of buffer");
`endif

endmodule
